/* hdl/ntc_pkg.sv */
// shared types, constants and the resistance-to-temperature curve
`default_nettype none
package ntc_pkg;
   localparam int TBL_N = 14;
   localparam int IDX_W = 4;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_PULLUP  = 2'd0;
   localparam logic [1:0] CSR_FLOOR   = 2'd1;
   localparam logic [1:0] CSR_CEILING = 2'd2;

   localparam logic [31:0] OPEN_OHMS = 32'hFFFF_FFFF;

   // one classified reading handed from the front to the back
   typedef struct packed {
      logic        open;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } ntc_item_type;

   // curve resistance column, falling
   function automatic logic [31:0] tbl_ohms(input logic [IDX_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         4'd0:    v = 32'd100700;
         4'd1:    v = 32'd47600;
         4'd2:    v = 32'd24000;
         4'd3:    v = 32'd12800;
         4'd4:    v = 32'd7190;
         4'd5:    v = 32'd4220;
         4'd6:    v = 32'd2238;
         4'd7:    v = 32'd1590;
         4'd8:    v = 32'd1000;
         4'd9:    v = 32'd653;
         4'd10:   v = 32'd437;
         4'd11:   v = 32'd300;
         4'd12:   v = 32'd210;
         4'd13:   v = 32'd177;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // curve temperature column in tenths, rising
   function automatic logic signed [12:0] tbl_tenths(input logic [IDX_W-1:0] idx);
      logic signed [12:0] v;
      case (idx)
         4'd0:    v = -13'sd400;
         4'd1:    v = -13'sd200;
         4'd2:    v = 13'sd0;
         4'd3:    v = 13'sd200;
         4'd4:    v = 13'sd400;
         4'd5:    v = 13'sd600;
         4'd6:    v = 13'sd860;
         4'd7:    v = 13'sd1000;
         4'd8:    v = 13'sd1200;
         4'd9:    v = 13'sd1400;
         4'd10:   v = 13'sd1600;
         4'd11:   v = 13'sd1800;
         4'd12:   v = 13'sd2000;
         4'd13:   v = 13'sd2102;
         default: v = 13'sd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

/* hdl/ntc_thermistor_temp_interp.sv */
// top level: thermistor reading to resistance and temperature
//
// A reading is taken at a clock edge with start high and busy low.
// The front stage forms pullup times reading and the divisor, registers
// them and hands the beat to a two-entry queue. The back part works one
// beat at a time: a restoring division gives the resistance, a search of
// the 14-row curve follows, and a second division interpolates. A reading
// clamped at either end of the curve skips the second division, and an
// open sensor skips both divisions.
// busy rises for the cycle after each accept and stays up while the
// queue is full, so up to three beats may wait ahead of the back part.
// Each result is shown for one cycle with rsp_valid high; the receiver
// cannot stall. Synchronous reset empties the queue and idles the back
// part; csr registers return to pullup 2490, floor -400, ceiling 2102.
// The user must write configuration only while no reading is in flight;
// the block itself does not enforce it.
`default_nettype none
module ntc_thermistor_temp_interp #(
   parameter int ADC_FULLSCALE = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [15:0]        req_raw_adc,
   output logic                    rsp_valid,
   output logic [31:0]             rsp_resistance_ohms,
   output logic signed [12:0]      rsp_temp_tenths,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import ntc_pkg::*;

   logic [15:0]        pullup_ff;
   logic signed [12:0] floor_ff, ceil_ff;
   logic               push, pop, q_full, q_empty;
   ntc_item_type       f_item, q_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pullup_ff <= 16'd2490;
         floor_ff  <= -13'sd400;
         ceil_ff   <= 13'sd2102;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PULLUP:  pullup_ff <= csr_wdata;
            CSR_FLOOR:   floor_ff  <= csr_wdata[12:0];
            CSR_CEILING: ceil_ff   <= csr_wdata[12:0];
            default:     ;
         endcase
      end
   end

   ntc_front #(.ADC_FULLSCALE(ADC_FULLSCALE)) u_front (
      .clock(clock), .reset(reset), .accept(start && !busy),
      .raw_adc(req_raw_adc), .pull_ohms(pullup_ff), .q_full(q_full),
      .push(push), .item(f_item), .busy(busy)
   );

   ntc_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .wr_item(f_item),
      .pop(pop), .rd_item(q_item), .full(q_full), .empty(q_empty)
   );

   ntc_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_item(q_item),
      .pop(pop), .floor_t(floor_ff), .ceil_t(ceil_ff),
      .rsp_valid(rsp_valid), .rsp_ohms(rsp_resistance_ohms),
      .rsp_temp(rsp_temp_tenths)
   );
endmodule
`default_nettype wire

/* hdl/ntc_div.sv */
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module ntc_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] rem_sh;
   logic        ge;

   // one shift-subtract step
   always_comb begin
      rem_sh  = {rem_ff[31:0], quo_ff[31]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[30:0], ge};
         rem_in = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

/* hdl/ntc_front.sv */
// front: takes a reading, forms pullup times reading and the divisor
`default_nettype none
module ntc_front #(
   parameter int ADC_FULLSCALE = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [15:0]          raw_adc,
   input  wire logic [15:0]          pull_ohms,
   input  wire logic                 q_full,
   output logic                      push,
   output ntc_pkg::ntc_item_type     item,
   output logic                      busy
);
   import ntc_pkg::*;

   logic         vld_ff, vld_in;
   ntc_item_type item_ff, item_in;

   // classify and multiply on accept
   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (vld_ff && !q_full) vld_in = 1'b0;
      if (accept) begin
         vld_in           = 1'b1;
         item_in.open     = {16'd0, raw_adc} >= 32'(ADC_FULLSCALE);
         item_in.dividend = {16'd0, pull_ohms} * {16'd0, raw_adc};
         item_in.divisor  = 32'(ADC_FULLSCALE) - {16'd0, raw_adc};
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= vld_in;
   end

   assign push = vld_ff && !q_full;
   assign item = item_ff;
   assign busy = vld_ff;
endmodule
`default_nettype wire

/* hdl/ntc_queue.sv */
// two-entry queue between front and back
`default_nettype none
module ntc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  ntc_pkg::ntc_item_type wr_item,
   input  wire logic             pop,
   output ntc_pkg::ntc_item_type rd_item,
   output logic                  full,
   output logic                  empty
);
   import ntc_pkg::*;

   ntc_item_type mem_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= wr_item;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign rd_item = mem_ff[rd_ff];
   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
endmodule
`default_nettype wire

/* hdl/ntc_back.sv */
// back: resistance division, curve search, interpolation division
`default_nettype none
module ntc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  ntc_pkg::ntc_item_type   q_item,
   output logic                    pop,
   input  wire logic signed [12:0] floor_t,
   input  wire logic signed [12:0] ceil_t,
   output logic                    rsp_valid,
   output logic [31:0]             rsp_ohms,
   output logic signed [12:0]      rsp_temp
);
   import ntc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RDIV = 5'b00010,
      S_LOOK = 5'b00100,
      S_IDIV = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type          st_ff, st_in;
   logic [31:0]        ohms_ff, ohms_in;
   logic signed [12:0] temp_ff, temp_in;
   logic signed [12:0] base_ff, base_in;
   logic               vld_ff, vld_in;
   logic               dv_start, dv_done;
   logic [31:0]        dv_a, dv_b, dv_q;
   logic [IDX_W-1:0]   k;
   logic [31:0]        span_r, off_r;
   logic [8:0]         span_t;

   ntc_div u_div (
      .clock(clock), .reset(reset), .start(dv_start),
      .dividend(dv_a), .divisor(dv_b), .done(dv_done), .quotient(dv_q)
   );

   // first row at or below the resistance
   always_comb begin
      k = IDX_W'(TBL_N - 1);
      for (int i = TBL_N - 1; i >= 1; i--) begin
         if (ohms_ff >= tbl_ohms(IDX_W'(i))) k = IDX_W'(i);
      end
      span_r = tbl_ohms(k - 4'd1) - tbl_ohms(k);
      off_r  = tbl_ohms(k - 4'd1) - ohms_ff;
      span_t = 9'(tbl_tenths(k) - tbl_tenths(k - 4'd1));
   end

   // sequencer
   always_comb begin
      st_in    = st_ff;
      ohms_in  = ohms_ff;
      temp_in  = temp_ff;
      base_in  = base_ff;
      vld_in   = 1'b0;
      pop      = 1'b0;
      dv_start = 1'b0;
      dv_a     = q_item.dividend;
      dv_b     = q_item.divisor;
      case (st_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               if (q_item.open) begin
                  ohms_in = OPEN_OHMS;
                  st_in   = S_LOOK;
               end else begin
                  dv_start = 1'b1;
                  st_in    = S_RDIV;
               end
            end
         end
         S_RDIV: begin
            if (dv_done) begin
               ohms_in = dv_q;
               st_in   = S_LOOK;
            end
         end
         S_LOOK: begin
            if (ohms_ff >= tbl_ohms(4'd0)) begin
               temp_in = floor_t;
               st_in   = S_OUT;
            end else if (ohms_ff <= tbl_ohms(IDX_W'(TBL_N - 1))) begin
               temp_in = ceil_t;
               st_in   = S_OUT;
            end else begin
               dv_a     = {23'd0, span_t} * {9'd0, off_r[22:0]};
               dv_b     = span_r;
               dv_start = 1'b1;
               base_in  = tbl_tenths(k - 4'd1);
               st_in    = S_IDIV;
            end
         end
         S_IDIV: begin
            if (dv_done) begin
               temp_in = base_ff + $signed({4'd0, dv_q[8:0]});
               st_in   = S_OUT;
            end
         end
         S_OUT: begin
            vld_in = 1'b1;
            st_in  = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ohms_ff <= ohms_in;
      temp_ff <= temp_in;
      base_ff <= base_in;
      if (reset) begin
         st_ff  <= S_IDLE;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_ohms  = ohms_ff;
   assign rsp_temp  = temp_ff;
endmodule
`default_nettype wire

/* hdl/ntc_checker.sv */
// port-level checks for the thermistor block, bound to the top level
`default_nettype none
module ntc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_resistance_ohms
);
   // results never come back to back
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("rsp_valid held two cycles");

   // a taken beat occupies the front stage
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy low after accept");

   // reset leaves nothing pending
   a_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy)) else $error("activity after reset");

   // a result beat carries a known resistance
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_resistance_ohms))
      else $error("unknown resistance on result");
endmodule

bind ntc_thermistor_temp_interp ntc_checker u_ntc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_resistance_ohms(rsp_resistance_ohms)
);
`default_nettype wire
